>>> hw/rtl/bfa_pkg.sv
`default_nettype none
package bfa_pkg;

  localparam int WORD_W  = 32;
  localparam int BIT_W   = 5;
  localparam int IDX_W   = 12;
  localparam int CNT_W   = 13;
  localparam int WADDR_W = 8;
  localparam int NW_W    = 9;

  localparam logic [1:0] OP_TAKE_INODE = 2'd0;
  localparam logic [1:0] OP_TAKE_BLOCK = 2'd1;
  localparam logic [1:0] OP_REL_INODE  = 2'd2;
  localparam logic [1:0] OP_REL_BLOCK  = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NONE_FREE = 2'd1;
  localparam logic [1:0] ST_RANGE     = 2'd2;
  localparam logic [1:0] ST_WAS_FREE  = 2'd3;

  localparam logic [0:0] REG_INODE_COUNT = 1'd0;
  localparam logic [0:0] REG_BLOCK_COUNT = 1'd1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_REL,
    S_PUSH
  } ctrl_state_t;

  typedef struct packed {
    logic                 rd_en;
    logic [WADDR_W-1:0]   rd_addr;
    logic                 wr_en;
    logic [WADDR_W-1:0]   wr_addr;
    logic [WORD_W-1:0]    wr_data;
  } map_req_t;

endpackage
`default_nettype wire

>>> hw/rtl/bfa_map_ram.sv
`default_nettype none
module bfa_map_ram #(
  parameter int DEPTH = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire bfa_pkg::map_req_t         req,
  output logic [bfa_pkg::WORD_W-1:0]     rd_data,
  output logic                           busy
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [bfa_pkg::WORD_W-1:0] mem [0:DEPTH-1];
  logic [bfa_pkg::WORD_W-1:0] rd_data_r;
  logic [AW-1:0]              clr_r;
  logic [AW-1:0]              clr_nxt;
  logic                       busy_r;
  logic                       busy_nxt;
  logic [31:0]                rd_a32;
  logic [31:0]                wr_a32;
  logic [AW-1:0]              rd_idx;
  logic [AW-1:0]              wr_idx;

  assign rd_a32 = 32'(req.rd_addr);
  assign wr_a32 = 32'(req.wr_addr);
  assign rd_idx = rd_a32[AW-1:0];
  assign wr_idx = wr_a32[AW-1:0];

  // clearing sweep after reset, one word a cycle
  always_comb begin
    clr_nxt  = clr_r;
    busy_nxt = busy_r;
    if (busy_r) begin
      clr_nxt = clr_r + AW'(1);
      if (clr_r == AW'(DEPTH - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      clr_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      clr_r  <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      mem[clr_r] <= '0;
    end else if (req.wr_en) begin
      mem[wr_idx] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[rd_idx];
    end
  end

  assign rd_data = rd_data_r;
  assign busy    = busy_r;

endmodule
`default_nettype wire

>>> hw/rtl/bfa_ctrl.sv
`default_nettype none
module bfa_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [1:0]                    in_op,
  input  wire logic [bfa_pkg::IDX_W-1:0]     in_idx,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [1:0]                         out_status,
  output logic [bfa_pkg::IDX_W-1:0]          out_grant,
  input  wire logic [bfa_pkg::CNT_W-1:0]     ino_cnt,
  input  wire logic [bfa_pkg::CNT_W-1:0]     blk_cnt,
  input  wire logic                          busy,
  output bfa_pkg::map_req_t                  ino_req,
  output bfa_pkg::map_req_t                  blk_req,
  input  wire logic [bfa_pkg::WORD_W-1:0]    ino_rdata,
  input  wire logic [bfa_pkg::WORD_W-1:0]    blk_rdata
);

  bfa_pkg::ctrl_state_t state_r, state_nxt;

  logic [1:0]                    op_r, op_nxt;
  logic [bfa_pkg::IDX_W-1:0]     idx_r, idx_nxt;
  logic [bfa_pkg::WADDR_W-1:0]   w_r, w_nxt;
  logic [1:0]                    res_status_r, res_status_nxt;
  logic [bfa_pkg::IDX_W-1:0]     res_grant_r, res_grant_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [1:0]                    out_status_r, out_status_nxt;
  logic [bfa_pkg::IDX_W-1:0]     out_grant_r, out_grant_nxt;

  logic                          in_fire;
  logic                          push_ok;
  logic [bfa_pkg::CNT_W-1:0]     cnt_in;
  logic [bfa_pkg::CNT_W-1:0]     cnt_cur;
  logic                          range_bad;
  logic [bfa_pkg::CNT_W:0]       cnt_round;
  logic [bfa_pkg::NW_W-1:0]      nw;
  logic [bfa_pkg::NW_W-1:0]      w_inc;
  logic                          more;
  logic [bfa_pkg::CNT_W-1:0]     lim;
  logic [bfa_pkg::WORD_W-1:0]    cur_data;
  logic [bfa_pkg::WORD_W-1:0]    vmask;
  logic [bfa_pkg::WORD_W-1:0]    avail;
  logic [bfa_pkg::WORD_W-1:0]    onehot;
  logic [bfa_pkg::BIT_W-1:0]     bitpos;
  logic                          found;
  logic [bfa_pkg::WORD_W-1:0]    rel_mask;
  logic [bfa_pkg::CNT_W-1:0]     grant_full;
  bfa_pkg::map_req_t             req;

  assign in_tready = (state_r == bfa_pkg::S_IDLE) && !busy;
  assign in_fire   = in_tvalid && in_tready;
  assign push_ok   = !out_valid_r || out_tready;

  assign cnt_in    = in_op[0] ? blk_cnt : ino_cnt;
  assign cnt_cur   = op_r[0] ? blk_cnt : ino_cnt;
  assign range_bad = bfa_pkg::CNT_W'(in_idx) >= cnt_in;

  // words to scan: ceil(count / 32)
  assign cnt_round = {1'b0, cnt_cur} + (bfa_pkg::CNT_W + 1)'(31);
  assign nw        = cnt_round[bfa_pkg::CNT_W:bfa_pkg::BIT_W];
  assign w_inc     = {1'b0, w_r} + bfa_pkg::NW_W'(1);
  assign more      = w_inc < nw;

  assign cur_data = op_r[0] ? blk_rdata : ino_rdata;
  assign lim      = cnt_cur - {w_r, bfa_pkg::BIT_W'(0)};

  // entries at or above the count look used
  always_comb begin
    for (int b = 0; b < bfa_pkg::WORD_W; b++) begin
      vmask[b] = bfa_pkg::CNT_W'(b) < lim;
    end
  end

  assign avail  = ~cur_data & vmask;
  assign onehot = avail & (~avail + bfa_pkg::WORD_W'(1));
  assign found  = avail != '0;

  always_comb begin
    bitpos = '0;
    for (int b = 0; b < bfa_pkg::WORD_W; b++) begin
      if (onehot[b]) begin
        bitpos = bitpos | bfa_pkg::BIT_W'(b);
      end
    end
  end

  assign grant_full = {w_r, bitpos};
  assign rel_mask   = bfa_pkg::WORD_W'(1) << idx_r[bfa_pkg::BIT_W-1:0];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bfa_pkg::S_IDLE: begin
        if (in_fire) begin
          if (!in_op[1]) begin
            state_nxt = (cnt_in == '0) ? bfa_pkg::S_PUSH : bfa_pkg::S_SCAN;
          end else begin
            state_nxt = range_bad ? bfa_pkg::S_PUSH : bfa_pkg::S_REL;
          end
        end
      end
      bfa_pkg::S_SCAN: begin
        if (found || !more) begin
          state_nxt = bfa_pkg::S_PUSH;
        end
      end
      bfa_pkg::S_REL: begin
        state_nxt = bfa_pkg::S_PUSH;
      end
      bfa_pkg::S_PUSH: begin
        if (push_ok) begin
          state_nxt = bfa_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = bfa_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    req            = '0;
    op_nxt         = op_r;
    idx_nxt        = idx_r;
    w_nxt          = w_r;
    res_status_nxt = res_status_r;
    res_grant_nxt  = res_grant_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_grant_nxt  = out_grant_r;
    case (state_r)
      bfa_pkg::S_IDLE: begin
        if (in_fire) begin
          op_nxt        = in_op;
          idx_nxt       = in_idx;
          w_nxt         = '0;
          res_grant_nxt = '0;
          if (!in_op[1]) begin
            res_status_nxt = bfa_pkg::ST_NONE_FREE;
            if (cnt_in != '0) begin
              req.rd_en   = 1'b1;
              req.rd_addr = '0;
            end
          end else begin
            res_status_nxt = bfa_pkg::ST_RANGE;
            if (!range_bad) begin
              req.rd_en   = 1'b1;
              req.rd_addr = {1'b0, in_idx[bfa_pkg::IDX_W-1:bfa_pkg::BIT_W]};
            end
          end
        end
      end
      bfa_pkg::S_SCAN: begin
        if (found) begin
          req.wr_en      = 1'b1;
          req.wr_addr    = w_r;
          req.wr_data    = cur_data | onehot;
          res_status_nxt = bfa_pkg::ST_OK;
          res_grant_nxt  = grant_full[bfa_pkg::IDX_W-1:0];
        end else if (more) begin
          // fetch the next word while this one is checked
          req.rd_en   = 1'b1;
          req.rd_addr = w_inc[bfa_pkg::WADDR_W-1:0];
          w_nxt       = w_inc[bfa_pkg::WADDR_W-1:0];
        end else begin
          res_status_nxt = bfa_pkg::ST_NONE_FREE;
          res_grant_nxt  = '0;
        end
      end
      bfa_pkg::S_REL: begin
        res_grant_nxt = '0;
        if ((cur_data & rel_mask) == '0) begin
          res_status_nxt = bfa_pkg::ST_WAS_FREE;
        end else begin
          req.wr_en      = 1'b1;
          req.wr_addr    = {1'b0, idx_r[bfa_pkg::IDX_W-1:bfa_pkg::BIT_W]};
          req.wr_data    = cur_data & ~rel_mask;
          res_status_nxt = bfa_pkg::ST_OK;
        end
      end
      bfa_pkg::S_PUSH: begin
        if (push_ok) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_grant_nxt  = res_grant_r;
        end
      end
      default: begin
        req = '0;
      end
    endcase
  end

  // route the request to the map the opcode names; the other map idles
  always_comb begin
    ino_req = '0;
    blk_req = '0;
    if (state_r == bfa_pkg::S_IDLE) begin
      if (in_op[0]) begin
        blk_req = req;
      end else begin
        ino_req = req;
      end
    end else if (op_r[0]) begin
      blk_req = req;
    end else begin
      ino_req = req;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bfa_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    idx_r        <= idx_nxt;
    w_r          <= w_nxt;
    res_status_r <= res_status_nxt;
    res_grant_r  <= res_grant_nxt;
    out_status_r <= out_status_nxt;
    out_grant_r  <= out_grant_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_status = out_status_r;
  assign out_grant  = out_grant_r;

  a_one_map_written: assert property (@(posedge clk) disable iff (!rst_n)
    !(ino_req.wr_en && blk_req.wr_en))
    else $error("both bitmaps written in one cycle");

  a_load_from_push: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == bfa_pkg::S_PUSH))
    else $error("result loaded outside push state");

  a_grant_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != bfa_pkg::ST_OK) |-> out_grant_r == '0)
    else $error("granted index set on a failed transaction");

  a_release_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bfa_pkg::S_REL && req.wr_en) |-> req.wr_data[idx_r[bfa_pkg::BIT_W-1:0]] == 1'b0)
    else $error("release write leaves the entry bit set");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_fire)
    else $error("transaction accepted during clearing sweep");

endmodule
`default_nettype wire

>>> hw/rtl/dual_bitmap_first_fit_allocator.sv
// channel   dir  signals                    fields (lsb up)
// cfg       in   cfg_we/index/wdata         0 inode_count, 1 block_count
// in        in   in_tvalid/tready/tdata     opcode[1:0], entry_index[13:2]
// out       out  out_tvalid/tready/tdata    status[1:0], granted_index[13:2]
//
// after reset both bitmaps are cleared by a sweep, with in_tready low until it ends.
// take: reads bitmap words in order (one word per cycle from the map ram) until a free entry is found, then result.
// release: read, modify-write, result; an out-of-range index goes straight to the result.
// a finished result waits in the push state until the output register is free; one item is worked on at a time.
`default_nettype none
module dual_bitmap_first_fit_allocator #(
  parameter int MAX_INODES = 512,
  parameter int MAX_BLOCKS = 4096
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [0:0]                    cfg_index,
  input  wire logic [bfa_pkg::CNT_W-1:0]     cfg_wdata,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [15:0]                   in_tdata,   // opcode, entry_index, pad
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [15:0]                        out_tdata   // status, granted_index, pad
);

  localparam int INODE_WORDS = (MAX_INODES + 31) / 32;
  localparam int BLOCK_WORDS = (MAX_BLOCKS + 31) / 32;

  logic [9:0]                    inode_cnt_r, inode_cnt_nxt;
  logic [bfa_pkg::CNT_W-1:0]     block_cnt_r, block_cnt_nxt;
  logic [bfa_pkg::CNT_W-1:0]     ino_eff;
  logic [bfa_pkg::CNT_W-1:0]     blk_eff;
  bfa_pkg::map_req_t             ino_req;
  bfa_pkg::map_req_t             blk_req;
  logic [bfa_pkg::WORD_W-1:0]    ino_rdata;
  logic [bfa_pkg::WORD_W-1:0]    blk_rdata;
  logic                          ino_busy;
  logic                          blk_busy;
  logic [1:0]                    out_status;
  logic [bfa_pkg::IDX_W-1:0]     out_grant;

  always_comb begin
    inode_cnt_nxt = inode_cnt_r;
    block_cnt_nxt = block_cnt_r;
    if (cfg_we) begin
      case (cfg_index)
        bfa_pkg::REG_INODE_COUNT: inode_cnt_nxt = cfg_wdata[9:0];
        bfa_pkg::REG_BLOCK_COUNT: block_cnt_nxt = cfg_wdata;
        default: begin
          inode_cnt_nxt = inode_cnt_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inode_cnt_r <= 10'd512;
      block_cnt_r <= 13'd3584;
    end else begin
      inode_cnt_r <= inode_cnt_nxt;
      block_cnt_r <= block_cnt_nxt;
    end
  end

  // counts saturate at the map capacity
  assign ino_eff = (32'(inode_cnt_r) > 32'(MAX_INODES)) ?
                   bfa_pkg::CNT_W'(MAX_INODES) : bfa_pkg::CNT_W'(inode_cnt_r);
  assign blk_eff = (32'(block_cnt_r) > 32'(MAX_BLOCKS)) ?
                   bfa_pkg::CNT_W'(MAX_BLOCKS) : block_cnt_r;

  bfa_map_ram #(
    .DEPTH (INODE_WORDS)
  ) u_inode_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (ino_req),
    .rd_data (ino_rdata),
    .busy    (ino_busy)
  );

  bfa_map_ram #(
    .DEPTH (BLOCK_WORDS)
  ) u_block_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (blk_req),
    .rd_data (blk_rdata),
    .busy    (blk_busy)
  );

  bfa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_op      (in_tdata[1:0]),
    .in_idx     (in_tdata[13:2]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_status (out_status),
    .out_grant  (out_grant),
    .ino_cnt    (ino_eff),
    .blk_cnt    (blk_eff),
    .busy       (ino_busy || blk_busy),
    .ino_req    (ino_req),
    .blk_req    (blk_req),
    .ino_rdata  (ino_rdata),
    .blk_rdata  (blk_rdata)
  );

  assign out_tdata = {2'b00, out_grant, out_status};

endmodule
`default_nettype wire

>>> verif/tb_dual_bitmap_first_fit_allocator.sv
`timescale 1ns / 1ps
module tb_dual_bitmap_first_fit_allocator;
  import bfa_pkg::*;

  localparam int MAX_INODES     = 512;
  localparam int MAX_BLOCKS     = 4096;
  localparam int MAP_WORDS      = MAX_BLOCKS / WORD_W;
  localparam int N_PHASES       = 9;
  localparam int ITEMS_PER_PH   = 100;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 150;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic [IDX_W-1:0] granted;
    logic [1:0]       status;
  } alloc_result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t     kind;
    logic [1:0]    op;
    logic [0:0]    reg_sel;
    logic [12:0]   arg;
    bit            fixed;
    alloc_result_t want;
  } script_row_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [0:0]          cfg_index;
  logic [CNT_W-1:0]    cfg_wdata;
  logic                in_tvalid;
  logic                in_tready;
  logic [15:0]         in_tdata;   // opcode[1:0], entry_index[13:2], zero pad
  logic                out_tvalid;
  logic                out_tready;
  logic [15:0]         out_tdata;  // status[1:0], granted_index[13:2], pad

  // predictor state: map 0 holds inodes (low words only), map 1 holds blocks
  logic [WORD_W-1:0]   map_words [2][MAP_WORDS];
  logic [9:0]          inode_cfg;
  logic [12:0]         block_cfg;

  alloc_result_t       pending_results [$];
  int unsigned         inode_granted [$];
  int unsigned         block_granted [$];
  script_row_t         alloc_script [$];

  int unsigned         mismatch_count;
  int unsigned         items_sent;
  int unsigned         results_checked;
  int unsigned         phases_run;
  int unsigned         status_seen [4];
  int unsigned         stall_cycles;

  dual_bitmap_first_fit_allocator #(
    .MAX_INODES(MAX_INODES),
    .MAX_BLOCKS(MAX_BLOCKS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #1 clk = ~clk;

  function automatic int unsigned map_limit(bit is_block);
    if (is_block) begin
      return (block_cfg > MAX_BLOCKS) ? MAX_BLOCKS : block_cfg;
    end
    return (inode_cfg > MAX_INODES) ? MAX_INODES : inode_cfg;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // first-fit take or release on the selected bitmap
  task automatic allocate_or_release(input logic [1:0] op, input logic [IDX_W-1:0] idx,
                                     output alloc_result_t res);
    bit          is_block;
    bit          is_take;
    bit          found;
    int unsigned lim;
    res      = '0;
    is_block = (op == OP_TAKE_BLOCK) || (op == OP_REL_BLOCK);
    is_take  = (op == OP_TAKE_INODE) || (op == OP_TAKE_BLOCK);
    lim      = map_limit(is_block);
    found    = 1'b0;
    if (is_take) begin
      for (int unsigned i = 0; i < lim; i++) begin
        if (!map_words[is_block][i >> 5][i & 31]) begin
          map_words[is_block][i >> 5][i & 31] = 1'b1;
          res.granted = i[IDX_W-1:0];
          found = 1'b1;
          break;
        end
      end
      if (!found) res.status = ST_NONE_FREE;
    end else if (idx >= lim) begin
      res.status = ST_RANGE;
    end else if (!map_words[is_block][idx >> 5][idx & 31]) begin
      res.status = ST_WAS_FREE;
    end else begin
      map_words[is_block][idx >> 5][idx & 31] = 1'b0;
      res.status = ST_OK;
    end
  endtask

  function automatic script_row_t item_row(logic [1:0] op, logic [11:0] idx, bit fixed,
                                           logic [1:0] st, logic [11:0] gr);
    script_row_t row;
    row.kind         = ROW_ITEM;
    row.op           = op;
    row.reg_sel      = REG_INODE_COUNT;
    row.arg          = {1'b0, idx};
    row.fixed        = fixed;
    row.want.status  = st;
    row.want.granted = gr;
    return row;
  endfunction

  function automatic script_row_t cfg_row(logic [0:0] sel, logic [12:0] val);
    script_row_t row;
    row.kind    = ROW_CFG;
    row.op      = OP_TAKE_INODE;
    row.reg_sel = sel;
    row.arg     = val;
    row.fixed   = 1'b0;
    row.want    = '0;
    return row;
  endfunction

  // lowers valid, then waits for every outstanding result
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_count(input logic [0:0] sel, input logic [12:0] val);
    drain_results();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_wdata <= val;
    if (sel == REG_INODE_COUNT) inode_cfg = val[9:0];
    else block_cfg = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_item(input logic [1:0] op, input logic [IDX_W-1:0] idx,
                           input int unsigned gap, input bit fixed,
                           input alloc_result_t want);
    alloc_result_t predicted;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, idx, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    allocate_or_release(op, idx, predicted);
    pending_results.push_back(fixed ? want : predicted);
    items_sent++;
    if (predicted.status == ST_OK && op == OP_TAKE_INODE) inode_granted.push_back(predicted.granted);
    if (predicted.status == ST_OK && op == OP_TAKE_BLOCK) block_granted.push_back(predicted.granted);
  endtask

  // result sink with random back-pressure, with recurring quiet stretches in which it never stalls
  initial begin : result_sink
    int unsigned stall_left;
    int unsigned cyc;
    out_tready = 1'b0;
    stall_left = 0;
    cyc        = 0;
    forever begin
      @(negedge clk);
      cyc++;
      if (stall_left != 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        if ((cyc % 600) >= 150 && $urandom_range(0, 99) < 35) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin : result_check
    alloc_result_t got;
    alloc_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = alloc_result_t'(out_tdata[13:0]);
      results_checked++;
      status_seen[got.status]++;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result: status %0d granted %0d", got.status, got.granted);
      end else begin
        want = pending_results.pop_front();
        if (got != want) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("result %0d: expected status %0d granted %0d, got status %0d granted %0d",
                     results_checked, want.status, want.granted, got.status, got.granted);
        end
      end
    end
  end

  // only input transactions restart the count, so a result stream cannot mask a stuck input
  always @(posedge clk) begin
    if (in_tvalid && in_tready) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("dual_bitmap_first_fit_allocator: mismatch");
      $finish;
    end
  end

  initial begin : stimulus
    logic [1:0]       op;
    logic [IDX_W-1:0] idx;
    logic [12:0]      inode_val;
    logic [12:0]      block_val;
    int unsigned      lim;
    int unsigned      j;
    int unsigned      r;
    int unsigned      gap;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = REG_INODE_COUNT;
    cfg_wdata       = '0;
    in_tvalid       = 1'b0;
    in_tdata        = '0;
    mismatch_count  = 0;
    items_sent      = 0;
    results_checked = 0;
    phases_run      = 0;
    stall_cycles    = 0;
    foreach (status_seen[s]) status_seen[s] = 0;
    foreach (map_words[m, w]) map_words[m][w] = '0;
    inode_cfg = 10'd512;
    block_cfg = 13'd3584;

    // reset counts are 512 inodes, 3584 blocks
    alloc_script.push_back(item_row(OP_TAKE_INODE, 12'd0,    1, ST_OK,        12'd0));
    alloc_script.push_back(item_row(OP_TAKE_BLOCK, 12'd0,    1, ST_OK,        12'd0));
    alloc_script.push_back(item_row(OP_TAKE_INODE, 12'd0,    1, ST_OK,        12'd1));
    alloc_script.push_back(item_row(OP_REL_INODE,  12'd0,    1, ST_OK,        12'd0));
    alloc_script.push_back(item_row(OP_REL_INODE,  12'd0,    1, ST_WAS_FREE,  12'd0));
    alloc_script.push_back(item_row(OP_REL_INODE,  12'd512,  1, ST_RANGE,     12'd0));
    alloc_script.push_back(item_row(OP_REL_INODE,  12'd4095, 1, ST_RANGE,     12'd0));
    alloc_script.push_back(item_row(OP_REL_BLOCK,  12'd4095, 1, ST_RANGE,     12'd0));
    alloc_script.push_back(item_row(OP_REL_BLOCK,  12'd3583, 1, ST_WAS_FREE,  12'd0));
    // index field is ignored by a take
    alloc_script.push_back(item_row(OP_TAKE_INODE, 12'hABC,  1, ST_OK,        12'd0));
    // nothing managed at all
    alloc_script.push_back(cfg_row(REG_INODE_COUNT, 13'd0));
    alloc_script.push_back(item_row(OP_TAKE_INODE, 12'd0,    1, ST_NONE_FREE, 12'd0));
    alloc_script.push_back(item_row(OP_REL_INODE,  12'd0,    1, ST_RANGE,     12'd0));
    alloc_script.push_back(cfg_row(REG_BLOCK_COUNT, 13'd0));
    alloc_script.push_back(item_row(OP_TAKE_BLOCK, 12'd0,    1, ST_NONE_FREE, 12'd0));
    alloc_script.push_back(item_row(OP_REL_BLOCK,  12'd0,    1, ST_RANGE,     12'd0));
    // tiny maps that are already full
    alloc_script.push_back(cfg_row(REG_INODE_COUNT, 13'd2));
    alloc_script.push_back(cfg_row(REG_BLOCK_COUNT, 13'd1));
    alloc_script.push_back(item_row(OP_TAKE_INODE, 12'd0,    1, ST_NONE_FREE, 12'd0));
    alloc_script.push_back(item_row(OP_TAKE_BLOCK, 12'd0,    1, ST_NONE_FREE, 12'd0));
    alloc_script.push_back(item_row(OP_REL_BLOCK,  12'd0,    1, ST_OK,        12'd0));
    alloc_script.push_back(item_row(OP_TAKE_BLOCK, 12'd0,    1, ST_OK,        12'd0));
    // counts above capacity saturate, upper inode bits dropped
    alloc_script.push_back(cfg_row(REG_INODE_COUNT, 13'h1FFF));
    alloc_script.push_back(cfg_row(REG_BLOCK_COUNT, 13'h1FFF));
    alloc_script.push_back(item_row(OP_REL_BLOCK,  12'd4095, 1, ST_WAS_FREE,  12'd0));
    alloc_script.push_back(item_row(OP_TAKE_BLOCK, 12'd0,    1, ST_OK,        12'd1));
    alloc_script.push_back(item_row(OP_REL_INODE,  12'd511,  1, ST_WAS_FREE,  12'd0));
    alloc_script.push_back(item_row(OP_REL_INODE,  12'd512,  1, ST_RANGE,     12'd0));
    alloc_script.push_back(item_row(OP_TAKE_INODE, 12'd0,    0, ST_OK,        12'd0));
    alloc_script.push_back(item_row(OP_REL_BLOCK,  12'd1,    0, ST_OK,        12'd0));
    alloc_script.push_back(item_row(OP_REL_BLOCK,  12'h800,  0, ST_OK,        12'd0));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (alloc_script[i]) begin
      if (alloc_script[i].kind == ROW_CFG)
        write_count(alloc_script[i].reg_sel, alloc_script[i].arg);
      else
        send_item(alloc_script[i].op, alloc_script[i].arg[IDX_W-1:0], pick_gap(),
                  alloc_script[i].fixed, alloc_script[i].want);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0: begin inode_val = 13'd5;    block_val = 13'd37;   end
        1: begin inode_val = 13'd0;    block_val = 13'd0;    end
        2: begin inode_val = 13'd1;    block_val = 13'd1;    end
        3: begin inode_val = 13'h1FFF; block_val = 13'h1FFF; end
        4: begin inode_val = 13'd512;  block_val = 13'd4096; end
        5: begin inode_val = 13'd32;   block_val = 13'd64;   end
        6: begin
          inode_val = 13'($urandom_range(1, 64));
          block_val = 13'($urandom_range(1, 300));
        end
        7: begin
          inode_val = 13'($urandom_range(1, 20));
          block_val = 13'($urandom_range(30, 100));
        end
        default: begin
          inode_val = 13'($urandom);
          block_val = 13'($urandom);
        end
      endcase
      write_count(REG_INODE_COUNT, inode_val);
      write_count(REG_BLOCK_COUNT, block_val);
      phases_run++;
      for (int k = 0; k < ITEMS_PER_PH; k++) begin
        // hold off new requests until the block has emptied its pipe
        if (p == 4 && k == ITEMS_PER_PH / 2) drain_results();
        if ($urandom_range(0, 99) < 55) begin
          op  = $urandom_range(0, 1) ? OP_TAKE_BLOCK : OP_TAKE_INODE;
          idx = IDX_W'($urandom);
        end else begin
          op  = $urandom_range(0, 1) ? OP_REL_BLOCK : OP_REL_INODE;
          lim = map_limit(op == OP_REL_BLOCK);
          r   = $urandom_range(0, 99);
          if (r < 50 && op == OP_REL_BLOCK && block_granted.size() != 0) begin
            j   = $urandom_range(0, block_granted.size() - 1);
            idx = IDX_W'(block_granted[j]);
            block_granted.delete(j);
          end else if (r < 50 && op == OP_REL_INODE && inode_granted.size() != 0) begin
            j   = $urandom_range(0, inode_granted.size() - 1);
            idx = IDX_W'(inode_granted[j]);
            inode_granted.delete(j);
          end else if (r < 80) begin
            idx = IDX_W'($urandom_range(0, lim + 3));
          end else begin
            idx = IDX_W'($urandom);
          end
        end
        gap = ((k % 50) < 12) ? 0 : pick_gap();
        send_item(op, idx, gap, 1'b0, '0);
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("sent %0d requests over %0d random count settings plus a directed script",
             items_sent, phases_run);
    $display("results checked %0d: ok %0d, none free %0d, out of range %0d, already free %0d",
             results_checked, status_seen[ST_OK], status_seen[ST_NONE_FREE],
             status_seen[ST_RANGE], status_seen[ST_WAS_FREE]);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("dual_bitmap_first_fit_allocator: match");
    end else begin
      $display("%0d mismatches, %0d results still outstanding",
               mismatch_count, pending_results.size());
      $display("dual_bitmap_first_fit_allocator: mismatch");
    end
    $finish;
  end

endmodule
